/* rtl/core/stable_counting_sorter_assert.svh */
// Assertion macros for the stable counting sorter.
// Used by the top level only; expects a clock named clk and a reset named rst.
`ifndef STABLE_COUNTING_SORTER_ASSERT_SVH
`define STABLE_COUNTING_SORTER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SCS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SCS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/scs_pkg.sv */
// Shared constants, state type and controller/datapath structs for the
// stable counting sorter. No dependencies.
package scs_pkg;

  // Sizing
  localparam int MAX_ITEMS = 64;
  localparam int KEY_BITS  = 8;
  localparam int NUM_BINS  = 1 << KEY_BITS;
  localparam int IDX_W     = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

  // Stream field widths
  localparam int KEY_IN_W  = 8;
  localparam int VALUE_W   = 64;
  localparam int TDATA_W   = ((KEY_IN_W + VALUE_W + 7) / 8) * 8;
  localparam int REC_W     = KEY_BITS + VALUE_W;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_PFX_RD,
    ST_PFX_WR,
    ST_PL_REC,
    ST_PL_HIST,
    ST_PL_WR,
    ST_EM_RD,
    ST_EM_OUT
  } state_t;

  // Controller -> datapath
  typedef struct packed {
    logic ready;       // input slot open
    logic accept;      // input transaction this cycle
    logic load_item;   // store captured record, update histogram
    logic pfx_rd;      // read histogram bin k
    logic pfx_wr;      // write running sum to bin k
    logic pl_rec_rd;   // read record i-1
    logic pl_hist_rd;  // read histogram bin of that record's key
    logic pl_wr;       // place record, decrement bin
    logic em_rd;       // read sorted entry j
    logic out_load;    // load output register
    logic batch_clear; // reset batch state
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic             last_item;
    logic             pfx_done;
    logic             pl_done;
    logic             em_last;
    logic             out_free;
    logic             place_nz;
    logic             overflow;
    logic [CNT_W-1:0] total;
  } status_t;

endpackage

/* rtl/core/scs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module scs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                        clk,
  input  logic                                        wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                            wr_data,
  input  logic                                        rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                            rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read; data holds while rd_en is low
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/core/scs_ctrl.sv */
// Sequencing state machine for the stable counting sorter.
// Depends on scs_pkg; drives cmd_t, reads status_t.
module scs_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  input  scs_pkg::status_t st,
  output scs_pkg::cmd_t    cmd
);

  scs_pkg::state_t state;
  scs_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= scs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      scs_pkg::ST_IDLE: begin
        if (s_tvalid) state_next = scs_pkg::ST_LOAD;
      end
      scs_pkg::ST_LOAD: begin
        state_next = st.last_item ? scs_pkg::ST_PFX_RD : scs_pkg::ST_IDLE;
      end
      scs_pkg::ST_PFX_RD:  state_next = scs_pkg::ST_PFX_WR;
      scs_pkg::ST_PFX_WR: begin
        state_next = st.pfx_done ? scs_pkg::ST_PL_REC : scs_pkg::ST_PFX_RD;
      end
      scs_pkg::ST_PL_REC:  state_next = scs_pkg::ST_PL_HIST;
      scs_pkg::ST_PL_HIST: state_next = scs_pkg::ST_PL_WR;
      scs_pkg::ST_PL_WR: begin
        state_next = st.pl_done ? scs_pkg::ST_EM_RD : scs_pkg::ST_PL_REC;
      end
      scs_pkg::ST_EM_RD:   state_next = scs_pkg::ST_EM_OUT;
      scs_pkg::ST_EM_OUT: begin
        if (st.out_free) begin
          state_next = st.em_last ? scs_pkg::ST_IDLE : scs_pkg::ST_EM_RD;
        end
      end
      default: state_next = scs_pkg::ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd             = '0;
    cmd.ready       = (state == scs_pkg::ST_IDLE);
    cmd.accept      = (state == scs_pkg::ST_IDLE) && s_tvalid;
    cmd.load_item   = (state == scs_pkg::ST_LOAD);
    cmd.pfx_rd      = (state == scs_pkg::ST_PFX_RD);
    cmd.pfx_wr      = (state == scs_pkg::ST_PFX_WR);
    cmd.pl_rec_rd   = (state == scs_pkg::ST_PL_REC);
    cmd.pl_hist_rd  = (state == scs_pkg::ST_PL_HIST);
    cmd.pl_wr       = (state == scs_pkg::ST_PL_WR);
    cmd.em_rd       = (state == scs_pkg::ST_EM_RD);
    cmd.out_load    = (state == scs_pkg::ST_EM_OUT) && st.out_free;
    cmd.batch_clear = cmd.out_load && st.em_last;
  end

endmodule

/* rtl/core/scs_datapath.sv */
// Datapath of the stable counting sorter: record, histogram and sorted RAMs,
// batch counters and the output register. Depends on scs_pkg and scs_ram.
module scs_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  scs_pkg::cmd_t                cmd,
  output scs_pkg::status_t             st,
  input  logic [scs_pkg::TDATA_W-1:0]  s_tdata,
  input  logic                         s_tlast,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [scs_pkg::TDATA_W-1:0]  m_tdata,
  output logic                         m_tlast,
  output logic                         m_tuser
);

  // Captured input record
  logic [scs_pkg::KEY_BITS-1:0] key_q;
  logic [scs_pkg::VALUE_W-1:0]  value_q;
  logic                         last_q;

  // Batch state
  logic [scs_pkg::CNT_W-1:0]    total;
  logic [scs_pkg::KEY_BITS-1:0] largest;
  logic                         ovf;

  // Pass counters
  logic [scs_pkg::KEY_BITS-1:0] k;
  logic [scs_pkg::CNT_W-1:0]    sum;
  logic [scs_pkg::CNT_W-1:0]    i;
  logic [scs_pkg::IDX_W-1:0]    j;

  // Histogram valid bits; an invalid bin reads as zero
  logic [scs_pkg::NUM_BINS-1:0] hvalid;
  logic                         hv_q;

  // Output register
  logic [scs_pkg::KEY_BITS-1:0] out_key;
  logic [scs_pkg::VALUE_W-1:0]  out_value;
  logic                         out_last;
  logic                         out_ovf;

  // RAM ports
  logic                          hist_wr_en;
  logic [scs_pkg::KEY_BITS-1:0]  hist_wr_addr;
  logic [scs_pkg::CNT_W-1:0]     hist_wr_data;
  logic                          hist_rd_en;
  logic [scs_pkg::KEY_BITS-1:0]  hist_rd_addr;
  logic [scs_pkg::CNT_W-1:0]     hist_rd_data;
  logic [scs_pkg::CNT_W-1:0]     hist_cnt;
  logic                          rec_wr_en;
  logic [scs_pkg::REC_W-1:0]     rec_rd_data;
  logic [scs_pkg::KEY_BITS-1:0]  rec_key;
  logic [scs_pkg::CNT_W-1:0]     i_dec;
  logic [scs_pkg::CNT_W-1:0]     pos;
  logic [scs_pkg::REC_W-1:0]     srt_rd_data;
  logic [scs_pkg::KEY_BITS-1:0]  in_key;

  assign in_key   = scs_pkg::KEY_BITS'(s_tdata[scs_pkg::KEY_IN_W-1:0]);
  assign rec_key  = rec_rd_data[scs_pkg::KEY_BITS-1:0];
  assign hist_cnt = hv_q ? hist_rd_data : '0;
  assign i_dec    = i - 1'b1;
  assign pos      = hist_cnt - 1'b1;
  assign rec_wr_en = cmd.load_item && (total < scs_pkg::CNT_W'(scs_pkg::MAX_ITEMS));

  // Capture input transaction
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      key_q   <= in_key;
      value_q <= s_tdata[scs_pkg::KEY_IN_W +: scs_pkg::VALUE_W];
      last_q  <= s_tlast;
    end
  end

  // Batch bookkeeping: count, largest key, overflow
  always_ff @(posedge clk) begin
    if (rst || cmd.batch_clear) begin
      total   <= '0;
      largest <= '0;
      ovf     <= 1'b0;
    end else if (cmd.load_item) begin
      if (rec_wr_en) begin
        total <= total + 1'b1;
        if (key_q > largest) largest <= key_q;
      end else begin
        ovf <= 1'b1;
      end
    end
  end

  // Prefix, placement and emission counters
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      k   <= '0;
      sum <= '0;
    end
    if (cmd.pfx_wr) begin
      k   <= k + 1'b1;
      sum <= sum + hist_cnt;
      i   <= total;
    end
    if (cmd.pl_wr) begin
      i <= i_dec;
      j <= '0;
    end
    if (cmd.out_load) begin
      j <= j + 1'b1;
    end
  end

  // Histogram port selection
  always_comb begin
    hist_rd_en   = cmd.accept || cmd.pfx_rd || cmd.pl_hist_rd;
    priority if (cmd.accept)     hist_rd_addr = in_key;
    else if (cmd.pfx_rd)         hist_rd_addr = k;
    else                         hist_rd_addr = rec_key;

    hist_wr_en = (cmd.load_item && rec_wr_en) || cmd.pfx_wr || cmd.pl_wr;
    priority if (cmd.pfx_wr) begin
      hist_wr_addr = k;
      hist_wr_data = sum + hist_cnt;
    end else if (cmd.pl_wr) begin
      hist_wr_addr = rec_key;
      hist_wr_data = pos;
    end else begin
      hist_wr_addr = key_q;
      hist_wr_data = hist_cnt + 1'b1;
    end
  end

  // Valid bits, cleared at reset and after each batch
  always_ff @(posedge clk) begin
    if (rst || cmd.batch_clear) begin
      hvalid <= '0;
    end else if (hist_wr_en) begin
      hvalid[hist_wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (hist_rd_en) begin
      hv_q <= hvalid[hist_rd_addr];
    end
  end

  scs_ram #(.WIDTH(scs_pkg::CNT_W), .DEPTH(scs_pkg::NUM_BINS)) u_hist (
    .clk     (clk),
    .wr_en   (hist_wr_en),
    .wr_addr (hist_wr_addr),
    .wr_data (hist_wr_data),
    .rd_en   (hist_rd_en),
    .rd_addr (hist_rd_addr),
    .rd_data (hist_rd_data)
  );

  // Arrival-order record buffer
  scs_ram #(.WIDTH(scs_pkg::REC_W), .DEPTH(scs_pkg::MAX_ITEMS)) u_rec (
    .clk     (clk),
    .wr_en   (rec_wr_en),
    .wr_addr (total[scs_pkg::IDX_W-1:0]),
    .wr_data ({value_q, key_q}),
    .rd_en   (cmd.pl_rec_rd),
    .rd_addr (i_dec[scs_pkg::IDX_W-1:0]),
    .rd_data (rec_rd_data)
  );

  // Sorted buffer
  scs_ram #(.WIDTH(scs_pkg::REC_W), .DEPTH(scs_pkg::MAX_ITEMS)) u_sorted (
    .clk     (clk),
    .wr_en   (cmd.pl_wr),
    .wr_addr (pos[scs_pkg::IDX_W-1:0]),
    .wr_data (rec_rd_data),
    .rd_en   (cmd.em_rd),
    .rd_addr (j),
    .rd_data (srt_rd_data)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_key   <= srt_rd_data[scs_pkg::KEY_BITS-1:0];
      out_value <= srt_rd_data[scs_pkg::KEY_BITS +: scs_pkg::VALUE_W];
      out_last  <= st.em_last;
      out_ovf   <= ovf;
    end
  end

  assign m_tdata = scs_pkg::TDATA_W'({out_value, scs_pkg::KEY_IN_W'(out_key)});
  assign m_tlast = out_last;
  assign m_tuser = out_ovf;

  // Status
  always_comb begin
    st.last_item = last_q;
    st.pfx_done  = (k == largest);
    st.pl_done   = (i == scs_pkg::CNT_W'(1));
    st.em_last   = (scs_pkg::CNT_W'(j) + 1'b1 == total);
    st.out_free  = !m_tvalid || m_tready;
    st.place_nz  = (hist_cnt != '0);
    st.overflow  = ovf;
    st.total     = total;
  end

endmodule

/* rtl/core/stable_counting_sorter.sv */
// Stable counting sorter. Records (key, value) stream in on s_*, one per
// transaction; each is captured in ST_IDLE and stored in ST_LOAD before the
// next is taken. The record marked tlast closes the batch: the block then
// runs a histogram prefix pass over bins 0 to K (K = largest key in the
// batch), a placement pass over each stored record and an emission pass over
// each record (plus any m_tready stalls). At most 64 records are kept; extra
// records are dropped and m_tuser flags overflow on every result of that
// batch. Results leave in ascending key order, equal keys in arrival order,
// with m_tlast on the final one. No input is taken from the closing record
// until the last result has entered the output reg.
// Depends on scs_pkg, scs_ctrl, scs_datapath, scs_ram and the assert header.
`include "stable_counting_sorter_assert.svh"

module stable_counting_sorter (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [scs_pkg::TDATA_W-1:0] s_tdata,  // [7:0] item_key, [71:8] item_value
  input  logic                        s_tlast,  // last_item
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [scs_pkg::TDATA_W-1:0] m_tdata,  // [7:0] out_key, [71:8] out_value
  output logic                        m_tlast,  // last_out
  output logic                        m_tuser   // [0] overflow
);

  scs_pkg::cmd_t    cmd;
  scs_pkg::status_t st;

  scs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .st       (st),
    .cmd      (cmd)
  );

  scs_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .st       (st),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  assign s_tready = cmd.ready;

  // Checks
  `SCS_ASSERT_NOW(a_place_bin_nonzero, cmd.pl_wr, st.place_nz, "placement hit empty bin")
  `SCS_ASSERT_NEXT(a_batch_cleared, cmd.batch_clear, (st.total == '0) && !st.overflow, "batch not cleared")
  `SCS_ASSERT_NEXT(a_one_item_at_a_time, s_tvalid && s_tready, !s_tready, "input taken while busy")

endmodule
